// ----- src/rgb_led_blink_breathe_driver_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the RGB LED driver
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RGB_LED_BLINK_BREATHE_DRIVER_DEFINES_SVH
`define RGB_LED_BLINK_BREATHE_DRIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define RGBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define RGBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RGBD_ASSERT_IMP(lbl, ante, cons, msg)
`define RGBD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/rgbd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbd_pkg
// Shared types, codes and the cosine table builder for the RGB LED driver.
// ---------------------------------------------------------------------------
package rgbd_pkg;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_BLINK = 2'd2,
        FUNC_PULSE = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic CFG_BLINK_TIME = 1'b0;
    localparam logic CFG_PULSE_STEP = 1'b1;

    localparam logic [15:0] BLINK_TIME_RESET = 16'd200;
    localparam logic [15:0] PULSE_STEP_RESET = 16'd33;

    // Work for the back end: show a colour as is, or evaluate the wave
    typedef enum logic {
        OP_DIRECT = 1'b0,
        OP_WAVE   = 1'b1
    } op_kind_t;

    // colour[0] red, [1] green, [2] blue; intensity for direct, base for wave
    typedef struct packed {
        op_kind_t        kind;
        logic [2:0][7:0] colour;
    } op_t;

    localparam int OP_BITS = $bits(op_t);

    // Q1.15 scale and wave divider
    localparam int          COS_SCALE = 32767;
    localparam logic [23:0] ROUND_BIAS = 24'd16383;
    localparam logic [15:0] DIV_CONST  = 16'd32767;

    // Q30 constants for the table builder
    localparam int     Q30_BITS    = 30;
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    // Taylor denominators a*(a+1)
    localparam longint COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};
    localparam longint SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    // Cosine series in Q30, x in [0, pi/2)
    function automatic longint cos_series(input longint x);
        longint term;
        longint sum;
        term = Q30_ONE;
        sum  = term;
        for (int n = 0; n < 8; n++) begin
            term = (term * x) / Q30_ONE;
            term = (term * x) / Q30_ONE;
            term = -term / COS_DIV[n];
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Sine series in Q30, x in [0, pi/2)
    function automatic longint sin_series(input longint x);
        longint term;
        longint sum;
        term = x;
        sum  = term;
        for (int n = 0; n < 8; n++) begin
            term = (term * x) / Q30_ONE;
            term = (term * x) / Q30_ONE;
            term = -term / SIN_DIV[n];
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Table entry k as 32767 + cos in Q1.15, range 0..65534; used at elaboration
    function automatic int cos_rom_offset(input int k, input int table_bits);
        int     qb;
        int     q;
        int     r;
        longint x;
        longint v;
        longint mag;
        longint c;
        qb = table_bits - 2;
        q  = (k >> qb) & 3;
        r  = k & ((1 << qb) - 1);
        x  = (longint'(r) * Q30_HALF_PI) >>> qb;
        case (q)
            0:       v = cos_series(x);
            1:       v = -sin_series(x);
            2:       v = -cos_series(x);
            default: v = sin_series(x);
        endcase
        mag = (v < 0) ? -v : v;
        mag = (mag * COS_SCALE + (Q30_ONE >>> 1)) >>> Q30_BITS;
        if (mag > COS_SCALE) mag = COS_SCALE;
        c = (v < 0) ? -mag : mag;
        return int'(COS_SCALE + c);
    endfunction

endpackage

// ----- src/rgbd_ifs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB LED driver channel interfaces
// Command input, LED duty output and configuration write channels.
// ---------------------------------------------------------------------------

// Command channel: tick or colour command
interface rgbd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, func, red, green, blue, input ready);
    modport sink   (input valid, func, red, green, blue, output ready);
endinterface

// LED channel: inverted PWM duties
interface rgbd_led_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty_red;
    logic [7:0] duty_green;
    logic [7:0] duty_blue;

    modport source (output valid, duty_red, duty_green, duty_blue, input ready);
    modport sink   (input valid, duty_red, duty_green, duty_blue, output ready);
endinterface

// Configuration write channel
interface rgbd_cfg_if;
    logic        valid;
    logic        ready;
    logic        addr;
    logic [15:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/rgb_led_blink_breathe_driver.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_led_blink_breathe_driver
// Active-low RGB LED driver with steady colour, one-shot blink and breathing.
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle; items with no result retire at once.
// Each result passes the queue, then the registered cosine lookup, multiply
// and divide-and-invert stages before it is valid on the LED channel.
// A stalled output stops the whole back end; the input stalls once the queue fills.
// Reset: asynchronous, clears blink/pulse state, queue and pipeline valids;
// blink_time returns to 200 and pulse_step to 33.
// ---------------------------------------------------------------------------
`include "rgb_led_blink_breathe_driver_defines.svh"

module rgb_led_blink_breathe_driver
    import rgbd_pkg::*;
#(
    parameter int PHASE_BITS     = 16,
    parameter int COS_TABLE_BITS = 8,
    parameter int QUEUE_DEPTH    = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    rgbd_cmd_if.sink   cmd,
    rgbd_cfg_if.sink   cfg,
    rgbd_led_if.source led
);

    localparam int Q_WIDTH = OP_BITS + COS_TABLE_BITS;

    logic                      push;
    op_t                       push_op;
    logic [COS_TABLE_BITS-1:0] push_idx;
    logic                      q_full, q_empty, pop;
    logic [Q_WIDTH-1:0]        q_data;
    op_t                       q_op;
    logic [COS_TABLE_BITS-1:0] q_idx;
    logic                      set_accept;
    logic                      pulse_start;

    // Command front end
    rgbd_front #(
        .PHASE_BITS     (PHASE_BITS),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op),
        .push_idx (push_idx)
    );

    // Work queue
    rgbd_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_op, push_idx}),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign q_op  = op_t'(q_data[Q_WIDTH-1 -: OP_BITS]);
    assign q_idx = q_data[COS_TABLE_BITS-1:0];

    // Wave and duty back end
    rgbd_back #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_op    (q_op),
        .q_idx   (q_idx),
        .pop     (pop),
        .led     (led)
    );

    // Accepted commands of interest to the checks
    assign set_accept  = cmd.valid && cmd.ready && cmd.func == FUNC_SET;
    assign pulse_start = cmd.valid && cmd.ready && cmd.func == FUNC_PULSE &&
                         (cmd.red != 8'd0 || cmd.green != 8'd0 || cmd.blue != 8'd0);

    // Checks
    `RGBD_ASSERT_IMP(a_push_room, push, !q_full, "work pushed into a full queue")
    `RGBD_ASSERT_IMP(a_set_pushes, set_accept, push, "set colour produced no work")
    `RGBD_ASSERT_IMP(a_pulse_start_quiet, pulse_start, !push, "pulse start produced a result")
    `RGBD_ASSERT_NXT(a_push_not_empty, push, !q_empty, "queue empty after a push")

endmodule

// ----- src/rgbd_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbd_front
// Accepts commands and ticks, keeps blink/pulse state and queues LED work.
// ---------------------------------------------------------------------------
module rgbd_front
    import rgbd_pkg::*;
#(
    parameter int PHASE_BITS     = 16,
    parameter int COS_TABLE_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    rgbd_cmd_if.sink                  cmd,
    rgbd_cfg_if.sink                  cfg,
    input  logic                      q_full,
    output logic                      push,
    output op_t                       push_op,
    output logic [COS_TABLE_BITS-1:0] push_idx
);

    logic [15:0]           blink_time_val_reg;
    logic [15:0]           pulse_step_reg;
    logic                  blink_on_reg, blink_on_next;
    logic [15:0]           blink_elapsed_reg, blink_elapsed_next;
    logic                  pulse_on_reg, pulse_on_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [2:0][7:0]       base_reg, base_next;
    logic [15:0]           elapsed_inc;
    logic                  accept;
    logic [2:0][7:0]       cmd_colour;

    assign cmd.ready  = !q_full;
    assign cfg.ready  = 1'b1;
    assign accept     = cmd.valid && cmd.ready;
    assign cmd_colour = {cmd.blue, cmd.green, cmd.red};

    assign elapsed_inc = (blink_elapsed_reg == 16'hFFFF) ? blink_elapsed_reg
                                                         : blink_elapsed_reg + 16'd1;

    // Classify the transaction and work out the next state
    always_comb
    begin
        blink_on_next      = blink_on_reg;
        blink_elapsed_next = blink_elapsed_reg;
        pulse_on_next      = pulse_on_reg;
        phase_next         = phase_reg;
        base_next          = base_reg;
        push               = 1'b0;
        push_op.kind       = OP_DIRECT;
        push_op.colour     = '0;
        if (accept)
        begin
            case (func_t'(cmd.func))
                FUNC_TICK:
                begin
                    if (blink_on_reg)
                    begin
                        blink_elapsed_next = elapsed_inc;
                        if (elapsed_inc >= blink_time_val_reg)
                        begin
                            blink_on_next = 1'b0;
                            push          = 1'b1;
                        end
                    end
                    else if (pulse_on_reg)
                    begin
                        phase_next     = phase_reg + PHASE_BITS'(pulse_step_reg);
                        push           = 1'b1;
                        push_op.kind   = OP_WAVE;
                        push_op.colour = base_reg;
                    end
                end
                FUNC_SET:
                begin
                    push           = 1'b1;
                    push_op.colour = cmd_colour;
                end
                FUNC_BLINK:
                begin
                    blink_on_next      = 1'b1;
                    blink_elapsed_next = '0;
                    pulse_on_next      = 1'b0;
                    push               = 1'b1;
                    push_op.colour     = cmd_colour;
                end
                FUNC_PULSE:
                begin
                    blink_on_next = 1'b0;
                    if (cmd_colour == '0)
                    begin
                        pulse_on_next = 1'b0;
                        base_next     = '0;
                        push          = 1'b1;
                    end
                    else
                    begin
                        pulse_on_next = 1'b1;
                        phase_next    = {1'b1, {(PHASE_BITS-1){1'b0}}};
                        base_next     = cmd_colour;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Cosine table index from the new phase
    if (PHASE_BITS >= COS_TABLE_BITS)
    begin : g_idx_down
        assign push_idx = phase_next[PHASE_BITS-1 -: COS_TABLE_BITS];
    end
    else
    begin : g_idx_up
        assign push_idx = {phase_next, {(COS_TABLE_BITS-PHASE_BITS){1'b0}}};
    end

    // State and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_time_val_reg <= BLINK_TIME_RESET;
            pulse_step_reg     <= PULSE_STEP_RESET;
            blink_on_reg       <= 1'b0;
            blink_elapsed_reg  <= '0;
            pulse_on_reg       <= 1'b0;
            phase_reg          <= '0;
            base_reg           <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.addr == CFG_BLINK_TIME) blink_time_val_reg <= cfg.data;
                if (cfg.addr == CFG_PULSE_STEP) pulse_step_reg     <= cfg.data;
            end
            blink_on_reg      <= blink_on_next;
            blink_elapsed_reg <= blink_elapsed_next;
            pulse_on_reg      <= pulse_on_next;
            phase_reg         <= phase_next;
            base_reg          <= base_next;
        end
    end

endmodule

// ----- src/rgbd_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbd_fifo
// Small register queue between the command front end and the wave back end.
// ---------------------------------------------------------------------------
module rgbd_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- src/rgbd_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbd_back
// Three-stage pipeline: cosine lookup, scale multiply, divide and invert.
// ---------------------------------------------------------------------------
module rgbd_back
    import rgbd_pkg::*;
#(
    parameter int COS_TABLE_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  op_t                       q_op,
    input  logic [COS_TABLE_BITS-1:0] q_idx,
    output logic                      pop,
    rgbd_led_if.source                led
);

    localparam int LUT_SIZE = 2 ** COS_TABLE_BITS;

    // Cosine table, 32767 + cos in Q1.15
    logic [15:0] cos_lut [LUT_SIZE];
    for (genvar k = 0; k < LUT_SIZE; k++)
    begin : g_lut
        assign cos_lut[k] = 16'(cos_rom_offset(k, COS_TABLE_BITS));
    end

    logic                 en;
    logic                 s1_v_reg, s2_v_reg, out_v_reg;
    op_t                  s1_op_reg;
    logic [15:0]          s1_cos_reg;
    op_kind_t             s2_kind_reg;
    logic [2:0][7:0]      s2_colour_reg;
    logic [2:0][22:0]     s2_prod_reg;
    logic [2:0][7:0]      intensity;
    logic [2:0][7:0]      duty_reg;

    // Whole pipe advances unless the output holds an untaken result
    assign en  = !out_v_reg || led.ready;
    assign pop = en && !q_empty;

    // Divide by 32767: n = q0*2^15 + lo = q0*32767 + (lo + q0)
    always_comb
    begin
        logic [23:0] n;
        logic [8:0]  q0;
        logic [15:0] rem;
        logic [8:0]  q;
        for (int ch = 0; ch < 3; ch++)
        begin
            n   = {1'b0, s2_prod_reg[ch]} + ROUND_BIAS;
            q0  = n[23:15];
            rem = {1'b0, n[14:0]} + {7'b0, q0};
            q   = q0 + {8'b0, (rem >= DIV_CONST)};
            intensity[ch] = (s2_kind_reg == OP_WAVE) ? q[7:0] : s2_colour_reg[ch];
        end
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= !q_empty;
            s2_v_reg  <= s1_v_reg;
            out_v_reg <= s2_v_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg     <= q_op;
            s1_cos_reg    <= cos_lut[q_idx];
            s2_kind_reg   <= s1_op_reg.kind;
            s2_colour_reg <= s1_op_reg.colour;
            for (int ch = 0; ch < 3; ch++)
            begin
                s2_prod_reg[ch] <= s1_op_reg.colour[ch][7:1] * s1_cos_reg;
                duty_reg[ch]    <= ~intensity[ch];
            end
        end
    end

    assign led.valid      = out_v_reg;
    assign led.duty_red   = duty_reg[0];
    assign led.duty_green = duty_reg[1];
    assign led.duty_blue  = duty_reg[2];

endmodule

// ----- dv/tb_rgb_led_blink_breathe_driver.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgb_led_blink_breathe_driver
// Self-checking bench for the RGB LED driver: steady colour, one-shot blink
// and cosine breathing. A cycle-free model predicts the LED duties for each
// accepted command; a checker compares every LED transaction in order.
// ---------------------------------------------------------------------------
module tb_rgb_led_blink_breathe_driver;
    import rgbd_pkg::*;

    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned LIMIT_CYCLES = 800000;
    localparam longint      Q30_UNIT     = 64'sd1073741824;
    localparam longint      Q30_QUARTER  = 64'sd1686629713;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } led_duty_t;

    logic clk;
    logic rst_n;

    rgbd_cmd_if cmd_if ();
    rgbd_cfg_if cfg_if ();
    rgbd_led_if led_if ();

    rgb_led_blink_breathe_driver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .cfg   (cfg_if.sink),
        .led   (led_if.source)
    );

    // Model copy of the configuration and state
    logic [15:0] blink_time_cfg;
    logic [15:0] pulse_step_cfg;
    bit          blinking;
    logic [15:0] blink_ticks;
    bit          breathing;
    logic [15:0] phase_acc;
    logic [7:0]  base_rgb [3];
    int          cos_q15 [256];

    led_duty_t   duty_expected [$];

    // Bench controls and counters
    bit          cmd_gaps_on;
    bit          led_stalls_on;
    int unsigned led_hold_req;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned cmds_sent;
    int unsigned cmds_effective;
    int unsigned duties_checked;
    int unsigned cfg_writes;
    int unsigned long_holds;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Taylor series in Q30; odd selects sine, else cosine
    function automatic longint taylor_q30(input longint x, input bit odd);
        longint term;
        longint sum;
        longint a;
        term = odd ? x : Q30_UNIT;
        sum  = term;
        for (int n = 1; n <= 8; n++)
        begin
            a    = odd ? 2 * n : 2 * n - 1;
            term = (term * x) / Q30_UNIT;
            term = (term * x) / Q30_UNIT;
            term = -term / (a * (a + 1));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Q1.15 cosine table by quadrant symmetry
    task automatic build_cos_table();
        int     q;
        int     r;
        longint x;
        longint v;
        longint mag;
        for (int k = 0; k < 256; k++)
        begin
            q = k >> 6;
            r = k & 63;
            x = (longint'(r) * Q30_QUARTER) / 64;
            case (q)
                0:       v = taylor_q30(x, 1'b0);
                1:       v = -taylor_q30(x, 1'b1);
                2:       v = -taylor_q30(x, 1'b0);
                default: v = taylor_q30(x, 1'b1);
            endcase
            mag = (v < 0) ? -v : v;
            mag = (mag * 32767 + Q30_UNIT / 2) / Q30_UNIT;
            if (mag > 32767) mag = 32767;
            cos_q15[k] = (v < 0) ? -int'(mag) : int'(mag);
        end
    endtask

    // Wave intensity for one channel at the current phase
    function automatic logic [7:0] breathe_level(input logic [7:0] base);
        int c;
        int h;
        if (base == 8'd0) return 8'd0;
        c = cos_q15[phase_acc[15:8]];
        h = base >> 1;
        return 8'((h * (32767 + c) + 16383) / 32767);
    endfunction

    // Queue the duties for an intensity triple (active-low LED)
    task automatic push_duty(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        led_duty_t d;
        d.red   = 8'd255 - r;
        d.green = 8'd255 - g;
        d.blue  = 8'd255 - b;
        duty_expected.push_back(d);
    endtask

    // Model step for one accepted command
    task automatic predict_led_duty(input func_t f, input logic [7:0] r,
                                    input logic [7:0] g, input logic [7:0] b);
        if (!(f == FUNC_TICK && !blinking && !breathing)) cmds_effective++;
        case (f)
            FUNC_TICK:
            begin
                if (blinking)
                begin
                    if (blink_ticks != 16'hFFFF) blink_ticks = blink_ticks + 16'd1;
                    if (blink_ticks >= blink_time_cfg)
                    begin
                        blinking = 1'b0;
                        push_duty(8'd0, 8'd0, 8'd0);
                    end
                end
                else if (breathing)
                begin
                    phase_acc = phase_acc + pulse_step_cfg;
                    push_duty(breathe_level(base_rgb[0]), breathe_level(base_rgb[1]),
                              breathe_level(base_rgb[2]));
                end
            end
            FUNC_SET:
                push_duty(r, g, b);
            FUNC_BLINK:
            begin
                blinking    = 1'b1;
                blink_ticks = 16'd0;
                breathing   = 1'b0;
                push_duty(r, g, b);
            end
            default:
            begin
                blinking    = 1'b0;
                base_rgb[0] = r;
                base_rgb[1] = g;
                base_rgb[2] = b;
                if (r == 8'd0 && g == 8'd0 && b == 8'd0)
                begin
                    breathing = 1'b0;
                    push_duty(8'd0, 8'd0, 8'd0);
                end
                else
                begin
                    breathing = 1'b1;
                    phase_acc = 16'h8000;
                end
            end
        endcase
    endtask

    // Idle gap: mostly none or short, a few long
    function automatic int unsigned rand_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Colour byte biased toward the extremes
    function automatic logic [7:0] rand_byte();
        int unsigned p;
        p = $urandom_range(0, 15);
        if (p == 0) return 8'd0;
        if (p == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one command transaction; valid stays high when no gap follows
    task automatic send_cmd(input func_t f, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
        int unsigned gap;
        cmd_if.valid <= 1'b1;
        cmd_if.func  <= f;
        cmd_if.red   <= r;
        cmd_if.green <= g;
        cmd_if.blue  <= b;
        do @(posedge clk); while (cmd_if.ready !== 1'b1);
        predict_led_duty(f, r, g, b);
        cmds_sent++;
        gap = cmd_gaps_on ? rand_gap() : 0;
        if (gap != 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_tick();
        send_cmd(FUNC_TICK, rand_byte(), rand_byte(), rand_byte());
    endtask

    // Stop offering commands and wait for every queued duty, then the pipeline
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (duty_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_BLINK_TIME) blink_time_cfg = val;
        else pulse_step_cfg = val;
        cfg_writes++;
    endtask

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR: %s", msg);
    endtask

    // LED sink: random stalls plus long holds on request
    initial
    begin : led_sink
        int unsigned stall_left;
        stall_left   = 0;
        led_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (led_hold_req != 0)
            begin
                stall_left   = led_hold_req;
                led_hold_req = 0;
                long_holds++;
            end
            else if (stall_left == 0 && led_stalls_on)
                stall_left = rand_gap();
            if (stall_left != 0)
            begin
                led_if.ready <= 1'b0;
                stall_left--;
            end
            else
                led_if.ready <= 1'b1;
        end
    end

    // Compare each LED transaction with the oldest prediction
    always @(posedge clk)
    begin
        led_duty_t want;
        if (rst_n === 1'b1 && led_if.valid === 1'b1 && led_if.ready === 1'b1)
        begin
            if (duty_expected.size() == 0)
                log_failure($sformatf("unexpected LED transaction r=%0d g=%0d b=%0d",
                                      led_if.duty_red, led_if.duty_green, led_if.duty_blue));
            else
            begin
                want = duty_expected.pop_front();
                duties_checked++;
                if (led_if.duty_red !== want.red || led_if.duty_green !== want.green ||
                    led_if.duty_blue !== want.blue)
                    log_failure($sformatf({"duty #%0d: expected r=%0d g=%0d b=%0d, ",
                                           "got r=%0d g=%0d b=%0d"},
                                          duties_checked, want.red, want.green, want.blue,
                                          led_if.duty_red, led_if.duty_green, led_if.duty_blue));
            end
        end
    end

    // Cycle limit
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d duties outstanding",
                 cycle_count, duty_expected.size());
        $display("simulation failed");
        $finish;
    end

    // Extremes, every command and the named corner cases
    task automatic test_directed();
        cmd_gaps_on   = 1'b0;
        led_stalls_on = 1'b0;
        send_cmd(FUNC_SET, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_SET, 8'd255, 8'd255, 8'd255);
        send_cmd(FUNC_SET, 8'hAA, 8'h55, 8'h0F);
        send_tick();
        // zero blink time: first tick switches off
        write_reg(CFG_BLINK_TIME, 16'd0);
        send_cmd(FUNC_BLINK, 8'd12, 8'd34, 8'd56);
        send_tick();
        // set during blink shows at once, tick still ends the blink
        write_reg(CFG_BLINK_TIME, 16'd2);
        send_cmd(FUNC_BLINK, 8'd255, 8'd0, 8'd128);
        send_tick();
        send_cmd(FUNC_SET, 8'd1, 8'd2, 8'd3);
        send_tick();
        // breathing, set during pulse, pulse off
        send_cmd(FUNC_PULSE, 8'd255, 8'd128, 8'd1);
        send_tick();
        send_tick();
        send_cmd(FUNC_SET, 8'd9, 8'd9, 8'd9);
        send_tick();
        send_cmd(FUNC_PULSE, 8'd0, 8'd0, 8'd0);
        send_tick();
        // zero step: wave holds its value
        write_reg(CFG_PULSE_STEP, 16'd0);
        send_cmd(FUNC_PULSE, 8'd254, 8'd3, 8'd0);
        send_tick();
        send_tick();
        write_reg(CFG_PULSE_STEP, 16'hFFFF);
        write_reg(CFG_BLINK_TIME, 16'hFFFF);
        send_tick();
        send_cmd(FUNC_BLINK, 8'd0, 8'd0, 8'd0);
        send_tick();
        send_cmd(FUNC_PULSE, 8'd0, 8'd0, 8'd1);
        send_tick();
        drain_results();
    endtask

    // Long output hold while commands keep coming, then a full pause
    task automatic test_backpressure();
        cmd_gaps_on   = 1'b0;
        led_stalls_on = 1'b0;
        write_reg(CFG_PULSE_STEP, 16'd700);
        led_hold_req = 400;
        for (int i = 0; i < 30; i++)
            send_cmd(FUNC_SET, rand_byte(), rand_byte(), rand_byte());
        drain_results();
        led_hold_req = 250;
        send_cmd(FUNC_PULSE, rand_byte(), rand_byte(), 8'd200);
        for (int i = 0; i < 30; i++) send_tick();
        drain_results();
    endtask

    // Well-formed blink and pulse sequences with random content, plus noise
    task automatic test_random_phase(input int unsigned n, input bit idle_on,
                                     input logic [15:0] bt, input logic [15:0] ps);
        int unsigned target;
        int unsigned k;
        write_reg(CFG_BLINK_TIME, bt);
        write_reg(CFG_PULSE_STEP, ps);
        cmd_gaps_on   = idle_on;
        led_stalls_on = idle_on;
        target        = cmds_effective + n;
        while (cmds_effective < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    send_cmd(FUNC_BLINK, rand_byte(), rand_byte(), rand_byte());
                    k = (blink_time_cfg <= 20) ? blink_time_cfg + $urandom_range(0, 2)
                                               : $urandom_range(1, 20);
                    for (int i = 0; i < k; i++)
                        if ($urandom_range(0, 9) == 0)
                            send_cmd(FUNC_SET, rand_byte(), rand_byte(), rand_byte());
                        else
                            send_tick();
                end
                3, 4, 5:
                begin
                    send_cmd(FUNC_PULSE, rand_byte(), rand_byte(), rand_byte());
                    k = $urandom_range(1, 30);
                    for (int i = 0; i < k; i++) send_tick();
                end
                6:
                begin
                    send_cmd(FUNC_PULSE, 8'd0, 8'd0, 8'd0);
                    send_tick();
                end
                7:
                    send_cmd(FUNC_SET, rand_byte(), rand_byte(), rand_byte());
                8:
                begin
                    k = $urandom_range(1, 6);
                    for (int i = 0; i < k; i++)
                        send_cmd(func_t'($urandom_range(0, 3)), rand_byte(), rand_byte(),
                                 rand_byte());
                end
                default:
                begin
                    // interrupted sequences: pulse cut by blink or blink cut by pulse
                    if ($urandom_range(0, 1))
                    begin
                        send_cmd(FUNC_PULSE, rand_byte(), rand_byte(), rand_byte());
                        send_tick();
                        send_cmd(FUNC_BLINK, rand_byte(), rand_byte(), rand_byte());
                    end
                    else
                    begin
                        send_cmd(FUNC_BLINK, rand_byte(), rand_byte(), rand_byte());
                        send_tick();
                        send_cmd(FUNC_PULSE, rand_byte(), rand_byte(), rand_byte());
                    end
                    send_tick();
                    send_tick();
                end
            endcase
        end
        drain_results();
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.func    = FUNC_TICK;
        cmd_if.red     = 8'd0;
        cmd_if.green   = 8'd0;
        cmd_if.blue    = 8'd0;
        cfg_if.valid   = 1'b0;
        cfg_if.addr    = CFG_BLINK_TIME;
        cfg_if.data    = 16'd0;
        cmd_gaps_on    = 1'b0;
        led_stalls_on  = 1'b0;
        led_hold_req   = 0;
        cycle_count    = 0;
        fail_count     = 0;
        cmds_sent      = 0;
        cmds_effective = 0;
        duties_checked = 0;
        cfg_writes     = 0;
        long_holds     = 0;
        blink_time_cfg = BLINK_TIME_RESET;
        pulse_step_cfg = PULSE_STEP_RESET;
        blinking       = 1'b0;
        blink_ticks    = 16'd0;
        breathing      = 1'b0;
        phase_acc      = 16'd0;
        for (int i = 0; i < 3; i++) base_rgb[i] = 8'd0;
        build_cos_table();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_phase(200, 1'b1, 16'd3, PULSE_STEP_RESET);
        test_random_phase(200, 1'b0, 16'd0, 16'd1);
        test_random_phase(200, 1'b1, 16'hFFFF, 16'hFFFF);
        test_random_phase(200, 1'b1, 16'($urandom_range(1, 15)), 16'($urandom_range(1, 65535)));
        test_random_phase(200, 1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        test_random_phase(200, 1'b1, 16'd5, 16'd0);

        drain_results();
        $display("covered %0d commands (%0d effective), %0d LED duties checked",
                 cmds_sent, cmds_effective, duties_checked);
        $display("%0d register writes, %0d long output holds, %0d mismatches",
                 cfg_writes, long_holds, fail_count);
        if (fail_count == 0 && duty_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
